// ===== design/tfl_pkg.sv =====
// Shared types and constants for the thermal fan level controller.
// No dependencies; imported by every design module.
`default_nettype none
package tfl_pkg;

    localparam int unsigned TEMP_W   = 12;
    localparam int unsigned LEVEL_W  = 3;
    localparam int unsigned SEC_W    = 10;
    localparam int unsigned TPS_W    = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 12;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 3'd5;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_UP     = 3'd1,
        ACT_DOWN   = 3'd2,
        ACT_MODE   = 3'd3,
        ACT_TIMER  = 3'd4,
        ACT_SAMPLE = 3'd5
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_TH  = 3'd0,
        CFG_HIGH_TH   = 3'd1,
        CFG_LOW_TH    = 3'd2,
        CFG_CD_SEC    = 3'd3,
        CFG_TICKS_SEC = 3'd4
    } t_cfg_idx;

    localparam logic signed [TEMP_W-1:0] RST_ALARM_TH  = 12'sd640;
    localparam logic signed [TEMP_W-1:0] RST_HIGH_TH   = 12'sd480;
    localparam logic signed [TEMP_W-1:0] RST_LOW_TH    = 12'sd400;
    localparam logic        [SEC_W-1:0]  RST_CD_SEC    = 10'd600;
    localparam logic        [TPS_W-1:0]  RST_TICKS_SEC = 7'd100;

    typedef struct packed {
        logic signed [TEMP_W-1:0] alarm_th;
        logic signed [TEMP_W-1:0] high_th;
        logic signed [TEMP_W-1:0] low_th;
        logic        [SEC_W-1:0]  cd_sec;
        logic        [TPS_W-1:0]  ticks_sec;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               auto_ctl;
        logic               alarm;
        logic               armed;
        logic [SEC_W-1:0]   seconds;
        logic [TPS_W-1:0]   prescale;
    } t_state;

endpackage
`default_nettype wire

// ===== design/tfl_cfg_regs.sv =====
// Configuration register file for the fan controller.
// Depends on tfl_pkg.
`default_nettype none
module tfl_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [tfl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tfl_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output      tfl_pkg::t_cfg                 o_cfg
);
    import tfl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_th  <= RST_ALARM_TH;
            r_cfg.high_th   <= RST_HIGH_TH;
            r_cfg.low_th    <= RST_LOW_TH;
            r_cfg.cd_sec    <= RST_CD_SEC;
            r_cfg.ticks_sec <= RST_TICKS_SEC;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ALARM_TH:  r_cfg.alarm_th  <= i_cfg_data;
                CFG_HIGH_TH:   r_cfg.high_th   <= i_cfg_data;
                CFG_LOW_TH:    r_cfg.low_th    <= i_cfg_data;
                CFG_CD_SEC:    r_cfg.cd_sec    <= i_cfg_data[SEC_W-1:0];
                CFG_TICKS_SEC: r_cfg.ticks_sec <= i_cfg_data[TPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// ===== design/tfl_update.sv =====
// Next-state logic: applies one item (tick, key or sample) to the state.
// Depends on tfl_pkg.
`default_nettype none
module tfl_update (
    input  wire logic [2:0]                           i_action,
    input  wire logic signed [tfl_pkg::TEMP_W-1:0]    i_temp,
    input       tfl_pkg::t_cfg                        i_cfg,
    input       tfl_pkg::t_state                      i_state,
    output      tfl_pkg::t_state                      o_state
);
    import tfl_pkg::*;

    logic signed [TEMP_W:0]  diff;
    logic [TEMP_W-1:0]       d;
    logic [LEVEL_W-1:0]      prop_level;
    logic [TPS_W:0]          pre_inc;
    logic                    wrap;

    assign diff = {i_temp[TEMP_W-1], i_temp} - {i_cfg.high_th[TEMP_W-1], i_cfg.high_th};
    assign d    = diff[TEMP_W-1:0];
    // floor(d/16)+3, saturated at the top level
    assign prop_level = (d[TEMP_W-1:4] > 8'd2) ? MAX_LEVEL : ({1'b0, d[5:4]} + 3'd3);

    assign pre_inc = {1'b0, i_state.prescale} + 8'd1;
    assign wrap    = pre_inc >= {1'b0, i_cfg.ticks_sec};

    always_comb begin
        o_state = i_state;
        case (t_action'(i_action))
            ACT_TICK: begin
                if (wrap) begin
                    o_state.prescale = '0;
                    if (i_state.armed && (i_state.seconds != '0)) begin
                        o_state.seconds = i_state.seconds - 10'd1;
                        if (i_state.seconds == 10'd1) begin
                            o_state.armed = 1'b0;
                            o_state.level = '0;
                        end
                    end
                end else begin
                    o_state.prescale = pre_inc[TPS_W-1:0];
                end
            end
            ACT_UP: begin
                if (!i_state.auto_ctl && (i_state.level < MAX_LEVEL))
                    o_state.level = i_state.level + 3'd1;
            end
            ACT_DOWN: begin
                if (!i_state.auto_ctl && (i_state.level != '0))
                    o_state.level = i_state.level - 3'd1;
            end
            ACT_MODE: begin
                o_state.auto_ctl = !i_state.auto_ctl;
                if (i_state.auto_ctl)
                    o_state.level = '0;
            end
            ACT_TIMER: begin
                if (i_state.armed) begin
                    o_state.armed   = 1'b0;
                    o_state.seconds = '0;
                end else begin
                    o_state.armed   = 1'b1;
                    o_state.seconds = i_cfg.cd_sec;
                end
            end
            ACT_SAMPLE: begin
                if (i_state.auto_ctl) begin
                    if (i_temp >= i_cfg.alarm_th) begin
                        o_state.level = MAX_LEVEL;
                        o_state.alarm = 1'b1;
                    end else if (i_temp >= i_cfg.high_th) begin
                        if (i_state.level < MAX_LEVEL)
                            o_state.level = prop_level;
                        o_state.alarm = 1'b0;
                    end else if (i_temp < i_cfg.low_th) begin
                        o_state.level = '0;
                        o_state.alarm = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== design/thermal_fan_level_controller.sv =====
// Six-level thermal fan controller: takes one tick, key or temperature beat per
// cycle and reports the updated state. Each beat passes through one input register,
// then the state register, which also serves as the result register. A new beat is
// accepted every cycle as long as results are taken. Configuration writes are
// accepted at any time and apply to every beat that leaves the input register after
// the write, so write only while no beat is in flight.
// Depends on tfl_pkg, tfl_cfg_regs and tfl_update.
`default_nettype none
module thermal_fan_level_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] temperature, [15:12] zero
    input  wire logic [2:0]  s_tuser,   // [2:0] action
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [2:0] fan_speed, [3] auto_ctl, [4] alarm,
                                        // [5] timer_on, [15:6] seconds_left
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [tfl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tfl_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import tfl_pkg::*;

    t_cfg                     cfg;
    t_state                   r_state;
    t_state                   n_state;
    logic                     r_in_vld;
    logic [2:0]               r_in_action;
    logic signed [TEMP_W-1:0] r_in_temp;
    logic                     r_out_vld;
    logic                     out_free;
    logic                     advance;

    assign o_cfg_ready = 1'b1;

    tfl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tfl_update u_update (
        .i_action (r_in_action),
        .i_temp   (r_in_temp),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_state  (n_state)
    );

    assign out_free = !r_out_vld || m_tready;
    assign advance  = r_in_vld && out_free;
    assign s_tready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_action <= s_tuser;
            r_in_temp   <= s_tdata[TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld         <= 1'b0;
            r_state.level     <= '0;
            r_state.auto_ctl  <= 1'b1;
            r_state.alarm     <= 1'b0;
            r_state.armed     <= 1'b0;
            r_state.seconds   <= '0;
            r_state.prescale  <= '0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
            r_state   <= n_state;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {r_state.seconds, r_state.armed, r_state.alarm,
                       r_state.auto_ctl, r_state.level};

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.level <= MAX_LEVEL)
        else $error("fan level out of range");

    a_disarmed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.armed |-> (r_state.seconds == '0))
        else $error("seconds left while countdown disarmed");

    a_manual_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_action == ACT_MODE) && r_state.auto_ctl)
        |=> (!r_state.auto_ctl && (r_state.level == '0)))
        else $error("entering manual mode did not clear level");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without an item");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for thermal_fan_level_controller: stream beats in, predicted
// fan status compared field by field on every result beat. Needs tfl_pkg and the RTL.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tfl_pkg::*;

    localparam int GAP_MAX        = 8;
    localparam int HOLD_OFF       = 300;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT    = 40;
    localparam int TEMP_MIN       = -880;
    localparam int TEMP_MAX       = 2000;
    localparam int MAX_LVL        = int'(MAX_LEVEL);

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [SEC_W-1:0]   seconds;
        logic               timer_on;
        logic               alarm;
        logic               auto_ctl;
        logic [LEVEL_W-1:0] level;
    } t_fan_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    thermal_fan_level_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the controller settings and state
    int th_alarm  = int'(RST_ALARM_TH);
    int th_high   = int'(RST_HIGH_TH);
    int th_low    = int'(RST_LOW_TH);
    int cd_load   = int'(RST_CD_SEC);
    int tick_rate = int'(RST_TICKS_SEC);
    int lvl       = 0;
    bit auto_on   = 1'b1;
    bit alarm_on  = 1'b0;
    bit cd_armed  = 1'b0;
    int cd_secs   = 0;
    int tick_div  = 0;

    t_fan_status status_fifo[$];

    int gap_max     = GAP_MAX;
    int stall_max   = GAP_MAX;
    int hold_cycles = 0;
    int errors      = 0;
    int beats_sent  = 0;
    int results_ok  = 0;
    int reg_writes  = 0;
    int expiries    = 0;
    int alarm_hits  = 0;
    int quiet_cycles = 0;

    function automatic int clamp_temp(int v);
        return (v < TEMP_MIN) ? TEMP_MIN : (v > TEMP_MAX) ? TEMP_MAX : v;
    endfunction

    function automatic t_fan_status next_fan_status(t_action act, int temp);
        t_fan_status st;
        int p;
        int lv;
        case (act)
            ACT_TICK: begin
                p = tick_div + 1;
                if (p >= tick_rate) begin
                    p = 0;
                    if (cd_armed && cd_secs > 0) begin
                        cd_secs--;
                        if (cd_secs == 0) begin
                            cd_armed = 1'b0;
                            lvl = 0;
                            expiries++;
                        end
                    end
                end
                tick_div = p & 127;
            end
            ACT_UP:   if (!auto_on && lvl < MAX_LVL) lvl++;
            ACT_DOWN: if (!auto_on && lvl > 0) lvl--;
            ACT_MODE: begin
                auto_on = !auto_on;
                if (!auto_on) lvl = 0;
            end
            ACT_TIMER: begin
                if (cd_armed) begin
                    cd_armed = 1'b0;
                    cd_secs = 0;
                end else begin
                    cd_armed = 1'b1;
                    cd_secs = cd_load;
                end
            end
            ACT_SAMPLE: begin
                if (auto_on) begin
                    if (temp >= th_alarm) begin
                        lvl = MAX_LVL;
                        alarm_on = 1'b1;
                        alarm_hits++;
                    end else if (temp >= th_high) begin
                        if (lvl < MAX_LVL) begin
                            lv = (temp - th_high) / 16 + 3;
                            lvl = (lv > MAX_LVL) ? MAX_LVL : lv;
                        end
                        alarm_on = 1'b0;
                    end else if (temp < th_low) begin
                        lvl = 0;
                        alarm_on = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        st.level = lvl[LEVEL_W-1:0];
        st.auto_ctl = auto_on;
        st.alarm = alarm_on;
        st.timer_on = cd_armed;
        st.seconds = cd_secs[SEC_W-1:0];
        return st;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch @%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic send_beat(t_action act, int temp);
        int gap;
        logic [TEMP_W-1:0] t12;
        gap = $urandom_range(0, gap_max);
        t12 = temp[TEMP_W-1:0];
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {4'b0, t12};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        status_fifo.push_back(next_fan_status(act, temp));
        beats_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (status_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DAT_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ALARM_TH:  th_alarm = value;
            CFG_HIGH_TH:   th_high = value;
            CFG_LOW_TH:    th_low = value;
            CFG_CD_SEC:    cd_load = value;
            CFG_TICKS_SEC: tick_rate = value;
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int rand_temp();
        int off;
        off = int'($urandom_range(0, 80)) - 40;
        case ($urandom_range(0, 4))
            0: return int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
            1: return clamp_temp(th_alarm + off);
            2: return clamp_temp(th_high + off);
            3: return clamp_temp(th_low + off);
            default: return clamp_temp(th_high + int'($urandom_range(0, 64)));
        endcase
    endfunction

    task automatic random_beat();
        int r;
        t_action act;
        r = $urandom_range(0, 99);
        if (r < 36)      act = ACT_TICK;
        else if (r < 49) act = ACT_UP;
        else if (r < 62) act = ACT_DOWN;
        else if (r < 68) act = ACT_MODE;
        else if (r < 72) act = ACT_TIMER;
        else             act = ACT_SAMPLE;
        send_beat(act, (act == ACT_SAMPLE) ? rand_temp()
                                           : int'($urandom_range(0, 4095)) - 2048 >>> 1);
    endtask

    task automatic randomize_settings();
        int lo, hi, al;
        if ($urandom_range(0, 3) == 0) begin
            al = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
            hi = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
            lo = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
        end else begin
            lo = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
            hi = clamp_temp(lo + int'($urandom_range(0, 240)));
            al = clamp_temp(hi + int'($urandom_range(0, 320)));
        end
        if ($urandom_range(0, 3) != 0) write_reg(CFG_ALARM_TH, al);
        if ($urandom_range(0, 3) != 0) write_reg(CFG_HIGH_TH, hi);
        if ($urandom_range(0, 3) != 0) write_reg(CFG_LOW_TH, lo);
        if ($urandom_range(0, 2) != 0)
            write_reg(CFG_CD_SEC, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1023)
                                                               : $urandom_range(1, 8));
        if ($urandom_range(0, 2) != 0)
            write_reg(CFG_TICKS_SEC, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 127)
                                                                  : $urandom_range(1, 3));
    endtask

    task automatic test_temperature_bands();
        send_beat(ACT_SAMPLE, TEMP_MAX);
        send_beat(ACT_SAMPLE, 500);        // high band while at max level: level held
        send_beat(ACT_SAMPLE, TEMP_MIN);
        send_beat(ACT_SAMPLE, 480);
        send_beat(ACT_SAMPLE, 496);
        send_beat(ACT_SAMPLE, 639);        // proportional level saturates
        send_beat(ACT_SAMPLE, 440);        // middle band: no change
        send_beat(ACT_SAMPLE, 399);
        send_beat(ACT_SAMPLE, 640);
    endtask

    task automatic test_manual_keys();
        send_beat(ACT_MODE, 0);            // alarm stays set
        send_beat(ACT_SAMPLE, TEMP_MAX);   // ignored in manual
        send_beat(ACT_DOWN, 0);
        repeat (6) send_beat(ACT_UP, 0);
        send_beat(ACT_MODE, 0);
        send_beat(ACT_UP, 0);              // ignored in auto
    endtask

    task automatic test_countdown();
        drain_results();
        write_reg(CFG_CD_SEC, 2);
        write_reg(CFG_TICKS_SEC, 1);
        send_beat(ACT_TIMER, 0);
        send_beat(ACT_TICK, 0);
        send_beat(ACT_TICK, 0);            // expiry drops the level
        send_beat(ACT_TIMER, 0);
        send_beat(ACT_TIMER, 0);
        drain_results();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_ALARM_TH, TEMP_MAX);
        write_reg(CFG_HIGH_TH, TEMP_MIN);
        write_reg(CFG_LOW_TH, TEMP_MIN);
        write_reg(CFG_CD_SEC, 1);
        write_reg(CFG_TICKS_SEC, 1);
        repeat (60) random_beat();
        drain_results();
        write_reg(CFG_ALARM_TH, TEMP_MIN);
        write_reg(CFG_HIGH_TH, TEMP_MAX);
        write_reg(CFG_LOW_TH, TEMP_MAX);
        write_reg(CFG_CD_SEC, 1023);
        write_reg(CFG_TICKS_SEC, 127);
        repeat (60) random_beat();
        drain_results();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 12; ph++) begin
            gap_max = (ph % 3 == 2) ? 0 : GAP_MAX;
            stall_max = (ph % 4 == 1) ? 0 : GAP_MAX;
            randomize_settings();
            repeat (114) random_beat();
            drain_results();
        end
        gap_max = GAP_MAX;
        stall_max = GAP_MAX;
    endtask

    task automatic test_backpressure();
        hold_cycles = HOLD_OFF;
        gap_max = 0;
        repeat (40) random_beat();
        drain_results();
        gap_max = GAP_MAX;
    endtask

    // result side ready, with random stalls and one long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                n = $urandom_range(0, stall_max);
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    task automatic check_status(t_fan_status got);
        t_fan_status want;
        if (status_fifo.size() == 0) begin
            report_mismatch("result beat with none pending", int'(got), 0);
            return;
        end
        want = status_fifo.pop_front();
        results_ok++;
        if (got.level != want.level)
            report_mismatch("fan_speed", int'(got.level), int'(want.level));
        if (got.auto_ctl != want.auto_ctl)
            report_mismatch("auto_ctl", int'(got.auto_ctl), int'(want.auto_ctl));
        if (got.alarm != want.alarm)
            report_mismatch("alarm", int'(got.alarm), int'(want.alarm));
        if (got.timer_on != want.timer_on)
            report_mismatch("timer_on", int'(got.timer_on), int'(want.timer_on));
        if (got.seconds != want.seconds)
            report_mismatch("seconds_left", int'(got.seconds), int'(want.seconds));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) check_status(t_fan_status'(m_tdata));
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_temperature_bands();
        test_manual_keys();
        test_countdown();
        test_config_extremes();
        test_random_phases();
        test_backpressure();
        drain_results();
        if (status_fifo.size() != 0)
            report_mismatch("results never delivered", status_fifo.size(), 0);
        $display("covered %0d input beats, %0d checked results, %0d register writes",
                 beats_sent, results_ok, reg_writes);
        $display("alarm samples %0d, countdown expiries %0d, mismatches %0d",
                 alarm_hits, expiries, errors);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/tfl_pkg.sv
design/tfl_cfg_regs.sv
design/tfl_update.sv
design/thermal_fan_level_controller.sv
tb/testbench.sv
